/* design/id_allocator_with_mask_table_top_assert.svh */
// assertion macros shared by the checker files
`ifndef ID_ALLOCATOR_WITH_MASK_TABLE_TOP_ASSERT_SVH
`define ID_ALLOCATOR_WITH_MASK_TABLE_TOP_ASSERT_SVH

// clocked assertion, disabled while reset is held
`define IDAMT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define IDAMT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/idamt_pkg.sv */
`timescale 1ns / 1ps
package idamt_pkg;

    localparam int DEF_NUM_ENTITIES   = 256;
    localparam int DEF_NUM_COMPONENTS = 32;

    // field widths of the stream words
    localparam int OPCODE_W    = 2;
    localparam int NUM_W       = 9;
    localparam int INIT_W      = 32;
    localparam int COMP_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    localparam logic [NUM_W-1:0] NONE_HELD = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_ADD      = 2'd2,
        OP_FREE_ALL = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

endpackage

/* design/idamt_ram.sv */
`timescale 1ns / 1ps
module idamt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/id_allocator_with_mask_table_top.sv */
`timescale 1ns / 1ps
// entity number allocator: numbers 0..NUM_ENTITIES-1 come from a lifo free stack held in
// one memory, and each number owns a component mask held in a second memory. opcode on
// s_axis_tuser picks allocate, free, add component bit or free all; every command word
// gives exactly one result word with a status on m_axis_tuser and the number now held on
// m_axis_tdata. allocate, free and add issue the registered memory reads in the accept cycle
// and modify and write back in the exec state that follows; free all walks the
// mask memory one entry a cycle. after reset a clearing pass zeroes the mask memory with
// s_axis_tready low. a result that is not taken holds the block in its last cycle until the
// output register frees.
module id_allocator_with_mask_table_top
    import idamt_pkg::*;
#(
    parameter int NUM_ENTITIES   = DEF_NUM_ENTITIES,
    parameter int NUM_COMPONENTS = DEF_NUM_COMPONENTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entity_number [8:0], initial_mask [40:9], component_index [46:41], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  logic [OPCODE_W-1:0]    s_axis_tuser,
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_number [8:0], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    localparam int IW = $clog2(NUM_ENTITIES);
    localparam int CW = $clog2(NUM_ENTITIES + 1);
    localparam int MW = (NUM_COMPONENTS > INIT_W) ? NUM_COMPONENTS : INIT_W;
    localparam logic [CW-1:0] N_CNT  = CW'(NUM_ENTITIES);
    localparam logic [CW-1:0] N_LAST = CW'(NUM_ENTITIES - 1);
    localparam logic [IW-1:0] TOP_NUM = IW'(NUM_ENTITIES - 1);

    // command word fields
    logic [NUM_W-1:0]  in_num;
    logic [INIT_W-1:0] in_init;
    logic [COMP_W-1:0] in_comp;
    logic              in_valid_num;
    logic              accept;

    assign in_num  = s_axis_tdata[8:0];
    assign in_init = s_axis_tdata[40:9];
    assign in_comp = s_axis_tdata[46:41];
    // negative or out of range means no number held
    assign in_valid_num = !in_num[NUM_W-1] &&
                          (32'(in_num[NUM_W-2:0]) < 32'(NUM_ENTITIES));

    // control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;   // stack fill
    logic [CW-1:0] r_min, n_min;       // lowest fill seen; slots at or above it were written
    logic [CW-1:0] r_idx, n_idx;       // sweep pointer for clearing and free all
    logic          r_wv, n_wv;         // walk read in flight
    logic [IW-1:0] r_widx, n_widx;     // entry whose mask arrives this cycle
    logic          r_out_valid;

    // latched command
    t_op               r_op;
    logic [NUM_W-1:0]  r_num;
    logic              r_num_ok;
    logic [INIT_W-1:0] r_init;
    logic [COMP_W-1:0] r_comp;

    // result register
    t_status          r_out_status;
    logic [NUM_W-1:0] r_out_num;

    // memory ports
    logic          m_we, m_re;
    logic [IW-1:0] m_waddr, m_raddr;
    logic [MW-1:0] m_wdata, m_rdata;
    logic          k_we, k_re;
    logic [IW-1:0] k_waddr, k_raddr;
    logic [IW-1:0] k_wdata, k_rdata;

    // datapath helpers
    logic             out_free;
    logic             load_out;
    t_status          res_status;
    logic [NUM_W-1:0] res_num;
    logic [IW-1:0]    num_addr;
    logic [IW-1:0]    top_slot;
    logic [IW-1:0]    pop_num;
    logic [CW-1:0]    cnt_dec;
    logic             can_push;
    logic             issue;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign num_addr = IW'(r_num[NUM_W-2:0]);
    assign cnt_dec  = r_count - 1'b1;
    assign top_slot = cnt_dec[IW-1:0];
    assign can_push = (r_count < N_CNT);
    assign issue    = (r_idx < N_CNT);
    // a slot never written since reset still holds its reset number
    assign pop_num  = (r_min < r_count) ? k_rdata : (TOP_NUM - top_slot);

    idamt_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_ENTITIES)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    idamt_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_ENTITIES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_re    (k_re),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= N_CNT;
            r_min       <= N_CNT;
            r_idx       <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_min   <= n_min;
            r_idx   <= n_idx;
            r_wv    <= n_wv;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx <= n_widx;
        if (accept) begin
            r_op     <= t_op'(s_axis_tuser);
            r_num    <= in_num;
            r_num_ok <= in_valid_num;
            r_init   <= in_init;
            r_comp   <= in_comp;
        end
        if (load_out) begin
            r_out_status <= res_status;
            r_out_num    <= res_num;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_min      = r_min;
        n_idx      = r_idx;
        n_wv       = 1'b0;
        n_widx     = r_widx;
        load_out   = 1'b0;
        res_status = ST_DONE;
        res_num    = NONE_HELD;
        m_we       = 1'b0;
        m_waddr    = num_addr;
        m_wdata    = '0;
        m_re       = 1'b0;
        m_raddr    = IW'(in_num[NUM_W-2:0]);
        k_we       = 1'b0;
        k_waddr    = r_count[IW-1:0];
        k_wdata    = num_addr;
        k_re       = 1'b0;
        k_raddr    = top_slot;

        unique case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_idx[IW-1:0];
                n_idx   = r_idx + 1'b1;
                if (r_idx == N_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                // both reads go out with the command; data is ready next cycle
                m_re = accept;
                k_re = accept;
                if (accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_op)
                    OP_ALLOC: begin
                        if (r_num_ok) begin
                            res_num = r_num;
                        end else if (r_count == '0) begin
                            res_status = ST_EMPTY;
                        end else begin
                            res_num = NUM_W'(pop_num);
                            if (out_free) begin
                                m_we    = 1'b1;
                                m_waddr = pop_num;
                                m_wdata = MW'(r_init);
                                n_count = cnt_dec;
                                if (cnt_dec < r_min) begin
                                    n_min = cnt_dec;
                                end
                            end
                        end
                    end

                    OP_FREE: begin
                        if (!r_num_ok || !can_push) begin
                            res_status = ST_IGNORED;
                        end
                        if (r_num_ok && out_free) begin
                            m_we = 1'b1;
                            if (can_push) begin
                                k_we    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                    end

                    OP_ADD: begin
                        if (!r_num_ok) begin
                            res_status = ST_IGNORED;
                        end else begin
                            res_num = r_num;
                            if (7'(r_comp) >= 7'(NUM_COMPONENTS)) begin
                                res_status = ST_IGNORED;
                            end else if (out_free) begin
                                m_we    = 1'b1;
                                m_wdata = m_rdata | (MW'(1) << r_comp);
                            end
                        end
                    end

                    OP_FREE_ALL: begin
                        n_idx   = '0;
                        n_state = S_WALK;
                    end

                    default: begin
                    end
                endcase

                if (r_op != OP_FREE_ALL && out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_WALK: begin
                // read entry r_idx while the previous entry is cleared and pushed
                m_re    = issue;
                m_raddr = r_idx[IW-1:0];
                n_wv    = issue;
                n_widx  = r_idx[IW-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_wv && (m_rdata != '0)) begin
                    m_we    = 1'b1;
                    m_waddr = r_widx;
                    if (can_push) begin
                        k_we    = 1'b1;
                        k_wdata = r_widx;
                        n_count = r_count + 1'b1;
                    end
                end
                if (!issue && !r_wv && out_free) begin
                    load_out = 1'b1;
                    n_idx    = '0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - NUM_W){1'b0}}, r_out_num};
    assign m_axis_tuser  = r_out_status;

endmodule

/* design/idamt_checker.sv */
`timescale 1ns / 1ps
`include "id_allocator_with_mask_table_top_assert.svh"
module idamt_checker
    import idamt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]    m_axis_tuser
);

    // a stalled result word keeps its content
    `IDAMT_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

    // one command at a time: no accept in the cycle after an accept
    `IDAMT_ASSERT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "command taken while previous one still running")

    // an empty stack never hands out a number
    `IDAMT_ASSERT(a_empty_none, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata[8:0] == NONE_HELD), "empty status with a number")

    // nothing comes out of reset
    `IDAMT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid && !s_axis_tready, "handshake active right after reset")

endmodule

bind id_allocator_with_mask_table_top idamt_checker u_idamt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/idamt_reply_checker.sv */
`timescale 1ns / 1ps
module idamt_reply_checker
    import idamt_pkg::*;
#(
    parameter int NUM_ENTITIES   = DEF_NUM_ENTITIES,
    parameter int NUM_COMPONENTS = DEF_NUM_COMPONENTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  logic                   i_cmd_ready,
    // entity_number [8:0], initial_mask [40:9], component_index [46:41], zero fill
    input  logic [IN_TDATA_W-1:0]  i_cmd_data,
    // opcode [1:0]
    input  logic [OPCODE_W-1:0]    i_cmd_op,
    input  logic                   i_reply_valid,
    input  logic                   i_reply_ready,
    // result_number [8:0], zero fill
    input  logic [OUT_TDATA_W-1:0] i_reply_data,
    // status [1:0]
    input  logic [STATUS_W-1:0]    i_reply_status,
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef struct packed {
        t_status           status;
        logic [NUM_W-1:0]  number;
    } t_reply;

    t_reply           expected_replies [$];
    t_reply           oldest_reply;
    logic [NUM_W-1:0] free_numbers [NUM_ENTITIES];
    int               free_count;
    logic [INIT_W-1:0] component_masks [NUM_ENTITIES];
    int               mismatch_count;

    // every number free with zero on top, masks cleared
    function automatic void clear_tables();
        int i;
        for (i = 0; i < NUM_ENTITIES; i++) begin
            free_numbers[i]    = NUM_W'(NUM_ENTITIES - 1 - i);
            component_masks[i] = '0;
        end
        free_count = NUM_ENTITIES;
    endfunction

    function automatic bit push_free(logic [NUM_W-1:0] n);
        if (free_count >= NUM_ENTITIES)
            return 1'b0;
        free_numbers[free_count] = n;
        free_count++;
        return 1'b1;
    endfunction

    function automatic t_reply predict_command(t_op op, logic [NUM_W-1:0] num,
                                               logic [INIT_W-1:0] init_mask,
                                               logic [COMP_W-1:0] comp);
        t_reply           r;
        logic             held;
        logic [NUM_W-1:0] n;
        int               i;
        held     = !num[NUM_W-1] && (int'(num) < NUM_ENTITIES);
        r.status = ST_DONE;
        r.number = NONE_HELD;
        case (op)
            OP_ALLOC: begin
                if (held) begin
                    r.number = num;
                end else if (free_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    free_count--;
                    n = free_numbers[free_count];
                    component_masks[n] = init_mask;
                    r.number = n;
                end
            end
            OP_FREE: begin
                if (!held) begin
                    r.status = ST_IGNORED;
                end else begin
                    component_masks[num] = '0;
                    if (!push_free(num))
                        r.status = ST_IGNORED;
                end
            end
            OP_ADD: begin
                if (!held) begin
                    r.status = ST_IGNORED;
                end else begin
                    r.number = num;
                    if (int'(comp) >= NUM_COMPONENTS)
                        r.status = ST_IGNORED;
                    else
                        component_masks[num] = component_masks[num] | (INIT_W'(1) << comp);
                end
            end
            default: begin
                // ascending walk, pushes onto a full stack are lost
                for (i = 0; i < NUM_ENTITIES; i++) begin
                    if (component_masks[i] != '0) begin
                        component_masks[i] = '0;
                        void'(push_free(NUM_W'(i)));
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tables();
            expected_replies.delete();
            mismatch_count = 0;
        end else begin
            if (i_cmd_valid && i_cmd_ready)
                expected_replies.insert(expected_replies.size(),
                    predict_command(t_op'(i_cmd_op),
                        i_cmd_data[NUM_W-1:0], i_cmd_data[NUM_W +: INIT_W],
                        i_cmd_data[NUM_W+INIT_W +: COMP_W]));
            if (i_reply_valid && i_reply_ready) begin
                if (expected_replies.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected reply status %0d number %0d", $time,
                                 i_reply_status, i_reply_data[NUM_W-1:0]);
                    mismatch_count++;
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    if (oldest_reply.status !== i_reply_status
                            || oldest_reply.number !== i_reply_data[NUM_W-1:0]) begin
                        if (mismatch_count < 10)
                            $display("%0t: expected status %0d number %h, got %0d %h",
                                     $time, oldest_reply.status, oldest_reply.number,
                                     i_reply_status, i_reply_data[NUM_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches = mismatch_count;
        o_pending    = expected_replies.size();
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import idamt_pkg::*;

    localparam int N_ENT           = DEF_NUM_ENTITIES;
    localparam int RANDOM_WORDS    = 1000;
    localparam int LIMIT_CYCLES    = 5000000;
    // long receiver hold-off so the block backs up and drops s_axis_tready
    localparam int HOLD_OFF_CYCLES = 400;
    // enough allocations to run the free stack dry from any state
    localparam int DRAIN_WORDS     = N_ENT + 14;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // entity_number [8:0], initial_mask [40:9], component_index [46:41], zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // opcode [1:0]
    logic [OPCODE_W-1:0]    s_axis_tuser  = OP_ALLOC;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // result_number [8:0], zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // status [1:0]
    logic [STATUS_W-1:0]    m_axis_tuser;

    int mismatches;
    int pending;
    int words_sent = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;       // sender runs back to back while set
    bit hold_req = 1'b0;    // asks the receiver for its long hold-off

    id_allocator_with_mask_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    idamt_reply_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (s_axis_tvalid),
        .i_cmd_ready    (s_axis_tready),
        .i_cmd_data     (s_axis_tdata),
        .i_cmd_op       (s_axis_tuser),
        .i_reply_valid  (m_axis_tvalid),
        .i_reply_ready  (m_axis_tready),
        .i_reply_data   (m_axis_tdata),
        .i_reply_status (m_axis_tuser),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: covers the clearing pass, free-all walks and every stall many times over
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // sender gaps: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // entity numbers: small numbers are the ones most likely handed out
    function automatic logic [NUM_W-1:0] pick_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return NONE_HELD;
        if (r < 28)
            return 9'h100 | NUM_W'($urandom_range(0, 255));
        if (r < 70)
            return NUM_W'($urandom_range(0, 15));
        return NUM_W'($urandom_range(0, N_ENT - 1));
    endfunction

    // offer one word and hold it until taken; valid stays up when no gap follows
    task automatic send_word(input t_op op, input logic [NUM_W-1:0] num,
                             input logic [INIT_W-1:0] mask, input logic [COMP_W-1:0] comp);
        int gap;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, comp, mask, num};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender stops until every outstanding reply has come back
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // one random command; masks are sometimes zero so free-all skips them
    task automatic random_word();
        int               r;
        logic [INIT_W-1:0] mask;
        logic [COMP_W-1:0] comp;
        r    = $urandom_range(0, 99);
        mask = ($urandom_range(0, 9) == 0) ? '0 : INIT_W'($urandom());
        comp = ($urandom_range(0, 9) < 6) ? COMP_W'($urandom_range(0, 31))
                                          : COMP_W'($urandom_range(32, 63));
        if (r < 35)
            send_word(OP_ALLOC, ($urandom_range(0, 9) < 7) ? NONE_HELD : pick_number(),
                      mask, comp);
        else if (r < 60)
            send_word(OP_FREE, pick_number(), mask, comp);
        else if (r < 96)
            send_word(OP_ADD, pick_number(), mask, comp);
        else
            send_word(OP_FREE_ALL, pick_number(), mask, comp);
    endtask

    // receiver: random ready stretches, plus one long hold-off on request
    initial begin
        int  on_len;
        int  off_len;
        int  held;
        int  r;
        bit  hold_taken;
        hold_taken = 1'b0;
        forever begin
            if (hold_req && !hold_taken) begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge i_clk);
                hold_taken = 1'b1;
            end else begin
                on_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 200)
                                                     : $urandom_range(1, 8);
                r = $urandom_range(0, 99);
                if (r < 55)
                    off_len = 1;
                else if (r < 85)
                    off_len = $urandom_range(2, 4);
                else if (r < 97)
                    off_len = $urandom_range(5, 15);
                else
                    off_len = $urandom_range(20, 60);
                m_axis_tready <= 1'b1;
                repeat (on_len) @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (off_len) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int directed_words;
        int burst_no;
        int len;
        int i;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, block comes out of reset with a full stack
        send_word(OP_FREE, 9'd5, 32'h0, 6'd0);              // free onto a full stack
        send_word(OP_ALLOC, NONE_HELD, 32'hFFFF_FFFF, 6'd63); // first pop gives zero
        send_word(OP_ALLOC, 9'd0, 32'h1234_5678, 6'd0);     // already holding a number
        send_word(OP_ALLOC, NONE_HELD, 32'h0, 6'd0);        // zero initial mask
        send_word(OP_ALLOC, 9'h100, 32'hA5A5_A5A5, 6'd21);  // most negative number
        send_word(OP_ADD, 9'd2, 32'h0, 6'd31);              // top valid component bit
        send_word(OP_ADD, 9'd2, 32'h0, 6'd32);              // first index out of range
        send_word(OP_ADD, 9'd2, 32'h0, 6'd63);              // largest index
        send_word(OP_ADD, NONE_HELD, 32'h0, 6'd0);          // add without a number
        send_word(OP_ADD, 9'd255, 32'hFFFF_FFFF, 6'd0);     // highest number
        send_word(OP_FREE, NONE_HELD, 32'h0, 6'd0);         // free without a number
        send_word(OP_FREE, 9'h1FE, 32'h0, 6'd0);            // other negative number
        send_word(OP_FREE, 9'd0, 32'h0, 6'd0);
        send_word(OP_FREE, 9'd0, 32'h0, 6'd0);              // same number freed twice
        send_word(OP_ADD, 9'd1, 32'h0, 6'd0);               // zero-mask entry gains a bit
        send_word(OP_FREE_ALL, NONE_HELD, 32'hFFFF_FFFF, 6'd63);
        send_word(OP_FREE, 9'd3, 32'h0, 6'd0);
        send_word(OP_ALLOC, NONE_HELD, 32'h0000_0001, 6'd1);
        send_word(OP_FREE_ALL, 9'd0, 32'h0, 6'd0);
        send_word(OP_FREE_ALL, 9'd0, 32'h0, 6'd0);          // nothing left to return
        directed_words = words_sent;

        // pause until every reply is back
        wait_until_drained();

        // first burst runs back to back while the receiver holds off
        hold_req <= 1'b1;
        burst_no  = 0;
        while (words_sent < directed_words + RANDOM_WORDS) begin
            quiet = (burst_no == 0) || ($urandom_range(0, 4) == 0);
            if (burst_no == 3 || $urandom_range(0, 19) == 0) begin
                // run the stack dry, then a few more to see it reported empty
                for (i = 0; i < DRAIN_WORDS; i++)
                    send_word(OP_ALLOC, NONE_HELD,
                              ($urandom_range(0, 15) == 0) ? '0 : INIT_W'($urandom()),
                              COMP_W'($urandom_range(0, 63)));
            end else begin
                len = (burst_no == 0) ? 60 : $urandom_range(10, 40);
                for (i = 0; i < len; i++)
                    random_word();
            end
            if ($urandom_range(0, 9) == 0)
                wait_until_drained();
            burst_no++;
        end
        quiet = 1'b0;

        // drain, then allow a full free-all walk for anything stray
        wait_until_drained();
        repeat (N_ENT + 16) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
